>>> rtl/iclt_pkg.sv
// shared types, codes and sizes of the involution cycle length table
package iclt_pkg;

  localparam int ICLT_MAX_ORBITS = 64;
  localparam int ICLT_MAX_OPS    = 8;
  localparam int ICLT_QUEUE_DEPTH = 2;

  localparam int REQ_W       = 2;
  localparam int OP_W        = 3;
  localparam int ORBIT_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int LEN_W       = 7;
  localparam int TOP_OP_W    = 3;
  localparam int ORBIT_CNT_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [TOP_OP_W-1:0]    TOP_OP_RESET    = TOP_OP_W'(3);
  localparam logic [ORBIT_CNT_W-1:0] ORBIT_CNT_RESET = ORBIT_CNT_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_OPERATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ORBIT_COUNT   = CFG_IDX_W'(1);

  localparam logic [REQ_W-1:0] REQ_CREATE = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_REMOVE = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_QUERY  = REQ_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE,
    STATUS_RANGE,
    STATUS_BLOCKED
  } status_t;

  typedef enum logic [1:0] {
    CMD_CREATE,
    CMD_REMOVE,
    CMD_QUERY,
    CMD_REJECT
  } cmd_kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_CHECK,
    ST_WRITE_B,
    ST_QUERY_START,
    ST_QUERY_SECOND,
    ST_QUERY_STEP
  } back_state_t;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   cycle_length;
  } result_t;

endpackage

>>> rtl/involution_cycle_length_table_unit.sv
// order: a link request reads both entries (READ_A, READ_B) and checks them; a blocked one
// queues its result in CHECK, else both are written (CHECK, WRITE_B) and WRITE_B queues it;
// a refused one is queued when taken; a query reads its start entry, then each walk step needs
// two dependent reads of the one read port; the sequencer holds one request; two requests
// queue ahead and two results behind; reset: control state clears, registers go to 3 and 1,
// then a clearing pass, with in_full high, writes all MAX_ORBITS * 2**clog2(MAX_OPS) entries
module involution_cycle_length_table_unit import iclt_pkg::*; #(
  parameter int MAX_ORBITS = ICLT_MAX_ORBITS,
  parameter int MAX_OPS    = ICLT_MAX_OPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [OP_W-1:0]       in_op_first,
  input  logic [ORBIT_W-1:0]    in_orbit_a,
  input  logic [ORBIT_W-1:0]    in_orbit_b,
  input  logic [OP_W-1:0]       in_op_second,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [STATUS_W-1:0]   out_status,
  output logic [LEN_W-1:0]      out_cycle_length
);

  localparam int OW    = $clog2(MAX_ORBITS);
  localparam int PW    = $clog2(MAX_OPS);
  localparam int CMD_W = 2 + 2 * OW + 2 * PW;
  localparam int RES_W = $bits(result_t);

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty, clearing;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
  logic             res_push, res_full;
  result_t          res_wdata, res_head;
  logic [RES_W-1:0] res_rdata;

  iclt_front #(
    .MAX_ORBITS (MAX_ORBITS),
    .MAX_OPS    (MAX_OPS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_req_type  (in_req_type),
    .in_op_first  (in_op_first),
    .in_orbit_a   (in_orbit_a),
    .in_orbit_b   (in_orbit_b),
    .in_op_second (in_op_second),
    .cmd_full     (cmd_full),
    .clearing     (clearing),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata)
  );

  iclt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (ICLT_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  iclt_back #(
    .MAX_ORBITS (MAX_ORBITS),
    .MAX_OPS    (MAX_OPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata),
    .clearing  (clearing)
  );

  iclt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (ICLT_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_head         = result_t'(res_rdata);
  assign out_status       = res_head.status;
  assign out_cycle_length = res_head.cycle_length;

endmodule

>>> rtl/iclt_ram.sv
// generic simple dual-port ram with registered read
module iclt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/iclt_fifo.sv
// small register queue between pipeline parts
module iclt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

>>> rtl/iclt_front.sv
// front part: configuration registers, request range checks and command build
module iclt_front import iclt_pkg::*; #(
  parameter int MAX_ORBITS = ICLT_MAX_ORBITS,
  parameter int MAX_OPS    = ICLT_MAX_OPS,
  localparam int OW    = $clog2(MAX_ORBITS),
  localparam int PW    = $clog2(MAX_OPS),
  localparam int CMD_W = 2 + 2 * OW + 2 * PW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [OP_W-1:0]       in_op_first,
  input  logic [ORBIT_W-1:0]    in_orbit_a,
  input  logic [ORBIT_W-1:0]    in_orbit_b,
  input  logic [OP_W-1:0]       in_op_second,
  input  logic                  cmd_full,
  input  logic                  clearing,
  output logic                  cmd_push,
  output logic [CMD_W-1:0]      cmd_data
);

  typedef struct packed {
    cmd_kind_t       kind;
    logic [PW-1:0]   op_first;
    logic [OW-1:0]   orbit_a;
    logic [OW-1:0]   orbit_b;
    logic [PW-1:0]   op_second;
  } cmd_t;

  logic [TOP_OP_W-1:0]    top_op_r, top_op_nxt;
  logic [ORBIT_CNT_W-1:0] orbit_count_r, orbit_count_nxt;
  logic                   op1_ok, op2_ok, a_ok, b_ok;
  cmd_t                   cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    top_op_nxt      = top_op_r;
    orbit_count_nxt = orbit_count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOP_OPERATION: top_op_nxt      = cfg_data[TOP_OP_W-1:0];
        CFG_ORBIT_COUNT:   orbit_count_nxt = cfg_data[ORBIT_CNT_W-1:0];
        default:           top_op_nxt      = top_op_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_op_r      <= TOP_OP_RESET;
      orbit_count_r <= ORBIT_CNT_RESET;
    end else begin
      top_op_r      <= top_op_nxt;
      orbit_count_r <= orbit_count_nxt;
    end
  end

  assign op1_ok = (in_op_first <= top_op_r) && (int'(in_op_first) < MAX_OPS);
  assign op2_ok = (in_op_second <= top_op_r) && (int'(in_op_second) < MAX_OPS);
  assign a_ok   = ({1'b0, in_orbit_a} < orbit_count_r) && (int'(in_orbit_a) < MAX_ORBITS);
  assign b_ok   = ({1'b0, in_orbit_b} < orbit_count_r) && (int'(in_orbit_b) < MAX_ORBITS);

  always_comb begin
    cmd.op_first  = PW'(in_op_first);
    cmd.orbit_a   = OW'(in_orbit_a);
    cmd.orbit_b   = OW'(in_orbit_b);
    cmd.op_second = PW'(in_op_second);
    unique case (in_req_type)
      REQ_CREATE: cmd.kind = (op1_ok && a_ok && b_ok) ? CMD_CREATE : CMD_REJECT;
      REQ_REMOVE: cmd.kind = (op1_ok && a_ok && b_ok) ? CMD_REMOVE : CMD_REJECT;
      REQ_QUERY:  cmd.kind = (op1_ok && op2_ok && a_ok) ? CMD_QUERY : CMD_REJECT;
      default:    cmd.kind = CMD_REJECT;
    endcase
  end

  assign in_full  = cmd_full || clearing;
  assign cmd_push = in_push && !in_full;
  assign cmd_data = cmd;

endmodule

>>> rtl/iclt_back.sv
// back part: table sequencer for link updates and cycle walks, plus clearing pass
module iclt_back import iclt_pkg::*; #(
  parameter int MAX_ORBITS = ICLT_MAX_ORBITS,
  parameter int MAX_OPS    = ICLT_MAX_OPS,
  localparam int OW        = $clog2(MAX_ORBITS),
  localparam int PW        = $clog2(MAX_OPS),
  localparam int AW        = OW + PW,
  localparam int TAB_DEPTH = MAX_ORBITS * (2 ** PW),
  localparam int SW        = $clog2(MAX_ORBITS + 1),
  localparam int CMD_W     = 2 + 2 * OW + 2 * PW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CMD_W-1:0] cmd_data,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output result_t          res_data,
  output logic             clearing
);

  typedef struct packed {
    cmd_kind_t       kind;
    logic [PW-1:0]   op_first;
    logic [OW-1:0]   orbit_a;
    logic [OW-1:0]   orbit_b;
    logic [PW-1:0]   op_second;
  } cmd_t;

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_in, cmd_r, cmd_nxt;
  logic [OW-1:0]      na_r, na_nxt;
  logic [SW-1:0]      steps_r, steps_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [OW-1:0]      ram_wdata, rd;
  logic               take, link_ok, walk_done, clear_last;
  logic [SW+LEN_W-1:0] len_ext;

  assign cmd_in     = cmd_t'(cmd_data);
  assign take       = !cmd_empty && !res_full;
  assign clear_last = (clr_r == AW'(TAB_DEPTH - 1));
  assign link_ok    = (cmd_r.kind == CMD_CREATE) ?
                      (na_r == cmd_r.orbit_a && rd == cmd_r.orbit_b) :
                      (na_r == cmd_r.orbit_b);
  assign walk_done  = (rd == cmd_r.orbit_a) || (steps_r == SW'(MAX_ORBITS));
  assign len_ext    = {{LEN_W{1'b0}}, steps_r};
  assign clearing   = (state_r == ST_CLEAR);

  iclt_ram #(
    .WIDTH (OW),
    .DEPTH (TAB_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:        if (clear_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_in.kind)
            CMD_REJECT: state_nxt = ST_IDLE;
            CMD_QUERY:  state_nxt = ST_QUERY_START;
            default:    state_nxt = ST_READ_A;
          endcase
        end
      end
      ST_READ_A:       state_nxt = ST_READ_B;
      ST_READ_B:       state_nxt = ST_CHECK;
      ST_CHECK:        state_nxt = link_ok ? ST_WRITE_B : ST_IDLE;
      ST_WRITE_B:      state_nxt = ST_IDLE;
      ST_QUERY_START:  state_nxt = ST_QUERY_SECOND;
      ST_QUERY_SECOND: state_nxt = ST_QUERY_STEP;
      ST_QUERY_STEP:   state_nxt = walk_done ? ST_IDLE : ST_QUERY_SECOND;
      default:         state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop               = 1'b0;
    res_push              = 1'b0;
    res_data.status       = STATUS_DONE;
    res_data.cycle_length = '0;
    ram_we                = 1'b0;
    ram_waddr             = {cmd_r.orbit_a, cmd_r.op_first};
    ram_wdata             = cmd_r.orbit_b;
    ram_raddr             = {cmd_r.orbit_a, cmd_r.op_first};
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = clr_r[AW-1:PW];
      end
      ST_IDLE: begin
        cmd_pop = take;
        if (take && cmd_in.kind == CMD_REJECT) begin
          res_push        = 1'b1;
          res_data.status = STATUS_RANGE;
        end
      end
      ST_READ_A:       ram_raddr = {cmd_r.orbit_a, cmd_r.op_first};
      ST_READ_B:       ram_raddr = {cmd_r.orbit_b, cmd_r.op_first};
      ST_CHECK: begin
        if (link_ok) begin
          ram_we    = 1'b1;
          ram_waddr = {cmd_r.orbit_a, cmd_r.op_first};
          ram_wdata = (cmd_r.kind == CMD_CREATE) ? cmd_r.orbit_b : cmd_r.orbit_a;
        end else begin
          res_push        = 1'b1;
          res_data.status = STATUS_BLOCKED;
        end
      end
      ST_WRITE_B: begin
        ram_we    = 1'b1;
        ram_waddr = {cmd_r.orbit_b, cmd_r.op_first};
        ram_wdata = (cmd_r.kind == CMD_CREATE) ? cmd_r.orbit_a : cmd_r.orbit_b;
        res_push  = 1'b1;
      end
      ST_QUERY_START:  ram_raddr = {cmd_r.orbit_a, cmd_r.op_first};
      ST_QUERY_SECOND: ram_raddr = {rd, cmd_r.op_second};
      ST_QUERY_STEP: begin
        ram_raddr = {rd, cmd_r.op_first};
        if (walk_done) begin
          res_push              = 1'b1;
          res_data.cycle_length = len_ext[LEN_W-1:0];
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    cmd_nxt   = cmd_r;
    na_nxt    = na_r;
    steps_nxt = steps_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: clr_nxt = clr_r + 1'b1;
      ST_IDLE: begin
        if (take) begin
          cmd_nxt   = cmd_in;
          steps_nxt = SW'(1);
        end
      end
      ST_READ_B:     na_nxt = rd;
      ST_QUERY_STEP: if (!walk_done) steps_nxt = steps_r + 1'b1;
      default:       na_nxt = na_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    na_r    <= na_nxt;
    steps_r <= steps_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!cmd_pop && !res_push))
    else $error("request handled during clearing pass");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUERY_STEP) |-> (steps_r <= SW'(MAX_ORBITS) && steps_r != '0))
    else $error("walk step count out of bounds");

  a_walk_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUERY_STEP && !walk_done) |=> (steps_r == $past(steps_r) + 1'b1))
    else $error("walk step count did not advance");

endmodule
